/* sv/gll_pkg.sv */
package gll_pkg;

	// Number of minute fraction digits kept (1 to 7)
	localparam int FRAC_DIGITS = 5;

	// Accumulator and datapath widths
	localparam int DEG_W   = 10;
	localparam int MIN_W   = 7;
	localparam int FRAC_W  = 24;
	localparam int CNT_W   = 4;
	localparam int HAVE_W  = 3;
	localparam int FLD_W   = 3;
	localparam int TIME_W  = 7;
	localparam int DIGIT_W = 4;
	localparam int FP_W    = 2 * FRAC_W;
	localparam int M_W     = 30;
	localparam int X_W     = M_W - 2;
	localparam int P_W     = X_W + 32;
	localparam int Q_W     = 25;
	localparam int DTERM_W = 34;
	localparam int MAG_W   = 31;

	// Characters
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SOUTH  = 8'h53;
	localparam logic [7:0] CH_WEST   = 8'h57;
	localparam logic [7:0] CH_VOID   = 8'h56;

	// Field positions within the sentence
	localparam logic [FLD_W-1:0] FLD_LAT      = 3'd1;
	localparam logic [FLD_W-1:0] FLD_LAT_HEMI = 3'd2;
	localparam logic [FLD_W-1:0] FLD_LON      = 3'd3;
	localparam logic [FLD_W-1:0] FLD_LON_HEMI = 3'd4;
	localparam logic [FLD_W-1:0] FLD_TIME     = 3'd5;
	localparam logic [FLD_W-1:0] FLD_STATUS   = 3'd6;
	localparam logic [FLD_W-1:0] FLD_LAST     = 3'd7;

	// Digit counting limits
	localparam logic [CNT_W-1:0] LAT_DEG_DIGITS = 4'd2;
	localparam logic [CNT_W-1:0] LON_DEG_DIGITS = 4'd3;
	localparam logic [CNT_W-1:0] CNT_MAX        = 4'd15;
	localparam logic [CNT_W-1:0] FRAC_CNT       = CNT_W'(FRAC_DIGITS);
	localparam logic [HAVE_W-1:0] HAVE_MAX      = 3'd7;
	localparam logic [MIN_W-1:0] MIN_MAX        = 7'd99;

	// Scaling constants
	localparam logic [FRAC_W-1:0] SCALE7  = 24'd10000000;
	localparam logic [31:0]       RECIP15 = 32'h11111111;
	localparam logic [X_W-1:0]    DIV15   = X_W'(15);
	localparam logic [MAG_W-1:0]  LAT_LIMIT = 31'd900000000;
	localparam logic [MAG_W-1:0]  LON_LIMIT = 31'd1800000000;

	typedef enum logic [1:0] {
		SEL_NONE,
		SEL_LAT,
		SEL_LON
	} coord_sel_t;

	// Event carried down the conversion pipeline
	typedef struct packed {
		logic              restart;
		logic              star;
		coord_sel_t        sel;
		logic              lat_neg;
		logic              lon_neg;
		logic [TIME_W-1:0] hours;
		logic [TIME_W-1:0] minutes;
		logic [TIME_W-1:0] seconds;
		logic [7:0]        status;
	} ev_t;

	// Snapshot of a finished coordinate field
	typedef struct packed {
		logic [DEG_W-1:0]  deg;
		logic [MIN_W-1:0]  mint;
		logic [FRAC_W-1:0] frac;
		logic [HAVE_W-1:0] have;
	} coord_t;

	// 10^e for e in 0..7
	function automatic logic [FRAC_W-1:0] pow10(input logic [HAVE_W-1:0] e);
		logic [FRAC_W-1:0] p;
		unique case (e)
			3'd0: p = 24'd1;
			3'd1: p = 24'd10;
			3'd2: p = 24'd100;
			3'd3: p = 24'd1000;
			3'd4: p = 24'd10000;
			3'd5: p = 24'd100000;
			3'd6: p = 24'd1000000;
			default: p = 24'd10000000;
		endcase
		return p;
	endfunction

endpackage

/* sv/gll_front.sv */
module gll_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [7:0]      char_in,
	input  logic            take,
	input  logic            adv,
	output logic            vld_s1,
	output gll_pkg::ev_t    ev_s1,
	output gll_pkg::coord_t crd_s1
);
	import gll_pkg::*;

	// Sentence and field state
	logic                           in_sent_q, in_sent_d;
	logic [FLD_W-1:0]               fld_q, fld_d;
	logic [DEG_W-1:0]               deg_q, deg_d;
	logic [MIN_W-1:0]               mint_q, mint_d;
	logic [FRAC_W-1:0]              frac_q, frac_d;
	logic [CNT_W-1:0]               cnt_q, cnt_d;
	logic                           point_q, point_d;
	logic                           lat_neg_q, lat_neg_d;
	logic                           lon_neg_q, lon_neg_d;
	logic [5:0][DIGIT_W-1:0]        tdig_q, tdig_d;
	logic [7:0]                     status_q, status_d;
	logic                           taken_q, taken_d;

	logic                 is_digit;
	logic [DIGIT_W-1:0]   dig;
	logic [CNT_W-1:0]     deg_lim;
	logic [9:0]           mint_sum;
	coord_sel_t           fin_sel;
	logic                 ev_vld;
	ev_t                  ev;
	coord_t               crd;

	assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
	assign dig      = DIGIT_W'(char_in - CH_ZERO);
	assign deg_lim  = (fld_q == FLD_LAT) ? LAT_DEG_DIGITS : LON_DEG_DIGITS;
	assign mint_sum = {3'b0, mint_q} * 10'd10 + {6'b0, dig};
	assign fin_sel  = (fld_q == FLD_LAT) ? SEL_LAT :
	                  (fld_q == FLD_LON) ? SEL_LON : SEL_NONE;

	// Snapshot of the field being closed
	assign crd.deg  = deg_q;
	assign crd.mint = mint_q;
	assign crd.frac = frac_q;
	assign crd.have = point_q ? cnt_q[HAVE_W-1:0] : '0;

	// Character decode and next state
	always_comb begin
		in_sent_d = in_sent_q;
		fld_d     = fld_q;
		deg_d     = deg_q;
		mint_d    = mint_q;
		frac_d    = frac_q;
		cnt_d     = cnt_q;
		point_d   = point_q;
		lat_neg_d = lat_neg_q;
		lon_neg_d = lon_neg_q;
		tdig_d    = tdig_q;
		status_d  = status_q;
		taken_d   = taken_q;

		ev_vld     = 1'b0;
		ev.restart = 1'b0;
		ev.star    = 1'b0;
		ev.sel     = SEL_NONE;
		ev.lat_neg = lat_neg_q;
		ev.lon_neg = lon_neg_q;
		ev.hours   = {3'b0, tdig_q[5]} * 7'd10 + {3'b0, tdig_q[4]};
		ev.minutes = {3'b0, tdig_q[3]} * 7'd10 + {3'b0, tdig_q[2]};
		ev.seconds = {3'b0, tdig_q[1]} * 7'd10 + {3'b0, tdig_q[0]};
		ev.status  = taken_q ? status_q : CH_STAR;

		if (char_in == CH_DOLLAR) begin
			// new sentence drops everything
			ev_vld     = 1'b1;
			ev.restart = 1'b1;
			in_sent_d  = 1'b1;
			fld_d      = '0;
			deg_d      = '0;
			mint_d     = '0;
			frac_d     = '0;
			cnt_d      = '0;
			point_d    = 1'b0;
			lat_neg_d  = 1'b0;
			lon_neg_d  = 1'b0;
			tdig_d     = '0;
			status_d   = CH_VOID;
			taken_d    = 1'b0;
		end else if (in_sent_q) begin
			if (char_in == CH_COMMA || char_in == CH_STAR) begin
				// close the field; coordinates go down the pipeline
				ev_vld  = (fin_sel != SEL_NONE) || (char_in == CH_STAR);
				ev.sel  = fin_sel;
				ev.star = (char_in == CH_STAR);
				deg_d   = '0;
				mint_d  = '0;
				frac_d  = '0;
				cnt_d   = '0;
				point_d = 1'b0;
				if (char_in == CH_STAR) begin
					in_sent_d = 1'b0;
				end else if (fld_q != FLD_LAST) begin
					fld_d = fld_q + 1'b1;
				end
			end else begin
				unique case (fld_q)
					FLD_LAT, FLD_LON: begin
						if (is_digit) begin
							if (point_q) begin
								if (cnt_q < FRAC_CNT) begin
									frac_d = FRAC_W'(frac_q * 10 + dig);
									cnt_d  = cnt_q + 1'b1;
								end
							end else begin
								if (cnt_q < deg_lim) begin
									deg_d = DEG_W'(deg_q * 10 + dig);
								end else begin
									mint_d = (mint_sum > 10'(MIN_MAX)) ? MIN_MAX
									                                  : mint_sum[MIN_W-1:0];
								end
								if (cnt_q < CNT_MAX) begin
									cnt_d = cnt_q + 1'b1;
								end
							end
						end else if (char_in == CH_POINT && !point_q) begin
							point_d = 1'b1;
							cnt_d   = '0;
						end
					end
					FLD_LAT_HEMI, FLD_LON_HEMI: begin
						// only the first character of the field counts
						if (cnt_q == '0) begin
							cnt_d = CNT_W'(1);
							if (fld_q == FLD_LAT_HEMI && char_in == CH_SOUTH) begin
								lat_neg_d = 1'b1;
							end
							if (fld_q == FLD_LON_HEMI && char_in == CH_WEST) begin
								lon_neg_d = 1'b1;
							end
						end
					end
					FLD_TIME: begin
						if (is_digit) begin
							if (!point_q) begin
								tdig_d = {tdig_q[4:0], dig};
							end
						end else if (char_in == CH_POINT) begin
							point_d = 1'b1;
						end
					end
					FLD_STATUS: begin
						if (!taken_q) begin
							status_d = char_in;
							taken_d  = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sent_q <= 1'b0;
			fld_q     <= '0;
			deg_q     <= '0;
			mint_q    <= '0;
			frac_q    <= '0;
			cnt_q     <= '0;
			point_q   <= 1'b0;
			lat_neg_q <= 1'b0;
			lon_neg_q <= 1'b0;
			tdig_q    <= '0;
			status_q  <= CH_VOID;
			taken_q   <= 1'b0;
		end else if (take) begin
			in_sent_q <= in_sent_d;
			fld_q     <= fld_d;
			deg_q     <= deg_d;
			mint_q    <= mint_d;
			frac_q    <= frac_d;
			cnt_q     <= cnt_d;
			point_q   <= point_d;
			lat_neg_q <= lat_neg_d;
			lon_neg_q <= lon_neg_d;
			tdig_q    <= tdig_d;
			status_q  <= status_d;
			taken_q   <= taken_d;
		end
	end

	// Event register, first pipeline stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= take && ev_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ev_s1  <= ev;
			crd_s1 <= crd;
		end
	end

endmodule

/* sv/gll_scale.sv */
module gll_scale (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       vld_s1,
	input  gll_pkg::ev_t               ev_s1,
	input  gll_pkg::coord_t            crd_s1,
	output logic                       vld_s5,
	output gll_pkg::ev_t               ev_s5,
	output logic [gll_pkg::MAG_W-1:0]  mag_s5
);
	import gll_pkg::*;

	logic vld_s2, vld_s3, vld_s4;
	ev_t  ev_s2, ev_s3, ev_s4;

	logic [M_W-1:0]     m_s2;
	logic [DTERM_W-1:0] dterm_s2, dterm_s3, dterm_s4;
	logic [X_W-1:0]     x_s3;
	logic [Q_W-1:0]     q0_s3, q_s4;

	// Stage 2: minutes scaled to 1e-7 units times 60
	logic [FRAC_W-1:0] pw;
	logic [FP_W-1:0]   frac_prod;
	logic [M_W-1:0]    mint_term;
	assign pw        = pow10(HAVE_MAX - crd_s1.have);
	assign frac_prod = FP_W'(crd_s1.frac) * FP_W'(pw);
	assign mint_term = M_W'(crd_s1.mint) * M_W'(SCALE7);

	// Stage 3: divide by 4, then estimate the quotient by 15
	logic [P_W-1:0] prod;
	assign prod = P_W'(m_s2[M_W-1:2]) * P_W'(RECIP15);

	// Stage 4: one correction step on the estimate
	logic [X_W-1:0] rem;
	assign rem = x_s3 - X_W'(q0_s3) * DIV15;

	// Stage 5: add degrees and clamp
	logic [DTERM_W-1:0] sum;
	logic [MAG_W-1:0]   lim;
	assign sum = dterm_s4 + DTERM_W'(q_s4);
	assign lim = (ev_s4.sel == SEL_LON) ? LON_LIMIT : LAT_LIMIT;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (adv) begin
			ev_s2    <= ev_s1;
			m_s2     <= M_W'(frac_prod) + mint_term;
			dterm_s2 <= DTERM_W'(crd_s1.deg) * DTERM_W'(SCALE7);

			ev_s3    <= ev_s2;
			x_s3     <= m_s2[M_W-1:2];
			q0_s3    <= prod[32 +: Q_W];
			dterm_s3 <= dterm_s2;

			ev_s4    <= ev_s3;
			q_s4     <= q0_s3 + Q_W'(rem >= DIV15);
			dterm_s4 <= dterm_s3;

			ev_s5    <= ev_s4;
			mag_s5   <= (sum > DTERM_W'(lim)) ? lim : sum[MAG_W-1:0];
		end
	end

endmodule

/* sv/nmea_gll_position_parser.sv */
// Channel  | Handshake               | Payload
// ---------+-------------------------+---------------------------------------------
// char     | char_valid, char_stall  | char_in
// pos      | pos_valid, pos_stall    | latitude, longitude, hours, minutes,
//          |                         | seconds, status
//
// One character is taken every cycle while char_stall is low. A result appears on pos
// after its '*' is taken and has passed a decode register, four conversion stages
// (scale, estimate by 15, correct, add and clamp) and the output register.
// Reset clears all control state at once; no startup pass is needed.
// char_stall is raised only while a result waits on pos_stall and the next
// result has already reached the last conversion stage.
module nmea_gll_position_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_stall,
	input  logic [7:0]         char_in,
	output logic               pos_valid,
	input  logic               pos_stall,
	output logic signed [30:0] latitude,
	output logic signed [31:0] longitude,
	output logic [6:0]         hours,
	output logic [6:0]         minutes,
	output logic [6:0]         seconds,
	output logic [7:0]         status
);
	import gll_pkg::*;

	logic             adv, take;
	logic             vld_s1, vld_s5;
	ev_t              ev_s1, ev_s5;
	coord_t           crd_s1;
	logic [MAG_W-1:0] mag_s5;

	logic [MAG_W-1:0]  lat_mag_q, lon_mag_q;
	logic              pos_valid_q;
	logic [MAG_W-1:0]  lat_q;
	logic [31:0]       lon_q;
	logic [TIME_W-1:0] hours_q, minutes_q, seconds_q;
	logic [7:0]        status_q;

	// Pipeline advances unless a second result would overrun the output
	assign adv        = !(pos_valid_q && pos_stall && vld_s5 && ev_s5.star);
	assign char_stall = !adv;
	assign take       = char_valid && adv;

	gll_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.char_in(char_in),
		.take   (take),
		.adv    (adv),
		.vld_s1 (vld_s1),
		.ev_s1  (ev_s1),
		.crd_s1 (crd_s1)
	);

	gll_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.vld_s1 (vld_s1),
		.ev_s1  (ev_s1),
		.crd_s1 (crd_s1),
		.vld_s5 (vld_s5),
		.ev_s5  (ev_s5),
		.mag_s5 (mag_s5)
	);

	// Coordinate magnitudes, possibly just finished by this item
	logic [MAG_W-1:0] lat_use, lon_use;
	assign lat_use = (ev_s5.sel == SEL_LAT) ? mag_s5 : lat_mag_q;
	assign lon_use = (ev_s5.sel == SEL_LON) ? mag_s5 : lon_mag_q;

	// Stored magnitudes of the current sentence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lat_mag_q <= '0;
			lon_mag_q <= '0;
		end else if (adv && vld_s5) begin
			if (ev_s5.restart) begin
				lat_mag_q <= '0;
				lon_mag_q <= '0;
			end else begin
				if (ev_s5.sel == SEL_LAT) begin
					lat_mag_q <= mag_s5;
				end
				if (ev_s5.sel == SEL_LON) begin
					lon_mag_q <= mag_s5;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_valid_q <= 1'b0;
		end else if (adv && vld_s5 && ev_s5.star) begin
			pos_valid_q <= 1'b1;
		end else if (!pos_stall) begin
			pos_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s5 && ev_s5.star) begin
			lat_q     <= ev_s5.lat_neg ? -lat_use : lat_use;
			lon_q     <= ev_s5.lon_neg ? -{1'b0, lon_use} : {1'b0, lon_use};
			hours_q   <= ev_s5.hours;
			minutes_q <= ev_s5.minutes;
			seconds_q <= ev_s5.seconds;
			status_q  <= ev_s5.status;
		end
	end

	assign pos_valid = pos_valid_q;
	assign latitude  = $signed(lat_q);
	assign longitude = $signed(lon_q);
	assign hours     = hours_q;
	assign minutes   = minutes_q;
	assign seconds   = seconds_q;
	assign status    = status_q;

	// Input is held back only behind a waiting result
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> pos_valid)
		else $error("char stalled with no result waiting");

	a_lat_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_valid |-> (latitude <= 31'sd900000000 && latitude >= -31'sd900000000))
		else $error("latitude out of range");

	a_lon_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_valid |-> (longitude <= 32'sd1800000000 && longitude >= -32'sd1800000000))
		else $error("longitude out of range");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && vld_s5 && ev_s5.restart) |=> (lat_mag_q == '0 && lon_mag_q == '0))
		else $error("sentence restart did not clear coordinates");

endmodule

/* bench/tb_top.sv */
module tb_top;
	import gll_pkg::*;

	localparam int LATENCY      = 5;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_CHARS = 1000;
	localparam int TIME_MOD     = 1000000;
	localparam int MAX_REPORTS  = 10;

	localparam logic [7:0] CH_NORTH = 8'h4E;
	localparam logic [7:0] CH_EAST  = 8'h45;
	localparam logic [7:0] CH_OK    = 8'h41;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	// One decoded position fix as seen on the output channel
	typedef struct packed {
		logic [30:0] lat;
		logic [31:0] lon;
		logic [6:0]  hh;
		logic [6:0]  mm;
		logic [6:0]  ss;
		logic [7:0]  st;
	} fix_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               char_valid;
	logic               char_stall;
	logic [7:0]         char_in;
	logic               pos_valid;
	logic               pos_stall;
	logic signed [30:0] latitude;
	logic signed [31:0] longitude;
	logic [6:0]         hours;
	logic [6:0]         minutes;
	logic [6:0]         seconds;
	logic [7:0]         status;

	nmea_gll_position_parser DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_in    (char_in),
		.pos_valid  (pos_valid),
		.pos_stall  (pos_stall),
		.latitude   (latitude),
		.longitude  (longitude),
		.hours      (hours),
		.minutes    (minutes),
		.seconds    (seconds),
		.status     (status)
	);

	always #2 clk = ~clk;

	// Parser state mirrored by the bench
	bit               in_sent;
	logic [FLD_W-1:0] fld;
	int unsigned      deg_acc;
	int unsigned      min_acc;
	int unsigned      frac_acc;
	int unsigned      ndig;
	int unsigned      time_acc;
	bit               point_seen;
	logic [31:0]      lat_acc;
	logic [31:0]      lon_acc;
	logic [7:0]       stat_ch;
	bit               stat_taken;

	fix_t        fix_q[$];
	logic [7:0]  line_q[$];
	int unsigned chars_sent = 0;
	int unsigned cycles = 0;
	int unsigned stall_left = 0;
	int          errors = 0;
	bit          idle_on = 1'b1;

	function automatic void clear_field();
		deg_acc    = 0;
		min_acc    = 0;
		frac_acc   = 0;
		ndig       = 0;
		point_seen = 1'b0;
	endfunction

	function automatic void open_sentence();
		in_sent    = 1'b1;
		fld        = '0;
		clear_field();
		lat_acc    = '0;
		lon_acc    = '0;
		time_acc   = 0;
		stat_ch    = CH_VOID;
		stat_taken = 1'b0;
	endfunction

	// Degrees plus minutes/60 in 1e-7 units, missing fraction digits as zeros
	function automatic logic [31:0] coord_mag(longint unsigned lim);
		longint unsigned sc;
		longint unsigned fr;
		longint unsigned mag;
		int unsigned     have;
		sc   = 1;
		fr   = frac_acc;
		have = point_seen ? ndig : 0;
		for (int k = 0; k < FRAC_DIGITS; k++) begin
			sc *= 10;
			if (k >= have)
				fr *= 10;
		end
		mag = longint'(deg_acc) * 64'd10000000
			+ ((longint'(min_acc) * sc + fr) * 64'd10000000) / (64'd60 * sc);
		if (mag > lim)
			mag = lim;
		return mag[31:0];
	endfunction

	function automatic void close_field();
		if (fld == FLD_LAT)
			lat_acc = coord_mag(LAT_LIMIT);
		else if (fld == FLD_LON)
			lon_acc = coord_mag(LON_LIMIT);
		clear_field();
	endfunction

	function automatic void coord_char(logic [7:0] c, int unsigned deg_digits);
		int unsigned d;
		int unsigned m;
		d = c - CH_ZERO;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			if (point_seen) begin
				if (ndig < FRAC_DIGITS) begin
					frac_acc = frac_acc * 10 + d;
					ndig++;
				end
			end else begin
				if (ndig < deg_digits) begin
					deg_acc = deg_acc * 10 + d;
				end else begin
					m       = min_acc * 10 + d;
					min_acc = (m > MIN_MAX) ? MIN_MAX : m;
				end
				if (ndig < CNT_MAX)
					ndig++;
			end
		end else if (c == CH_POINT && !point_seen) begin
			point_seen = 1'b1;
			ndig       = 0;
		end
	endfunction

	// Advance the mirrored parser by one character; a '*' yields one fix
	function automatic void parse_char(logic [7:0] c);
		int unsigned t;
		fix_t        f;
		if (c == CH_DOLLAR) begin
			open_sentence();
		end else if (in_sent) begin
			if (c == CH_COMMA) begin
				close_field();
				if (fld != FLD_LAST)
					fld++;
			end else if (c == CH_STAR) begin
				close_field();
				t    = time_acc % TIME_MOD;
				f.lat = lat_acc[30:0];
				f.lon = lon_acc;
				f.hh  = 7'((t / 10000) % 100);
				f.mm  = 7'((t / 100) % 100);
				f.ss  = 7'(t % 100);
				f.st  = stat_taken ? stat_ch : CH_STAR;
				fix_q.push_back(f);
				in_sent = 1'b0;
			end else begin
				case (fld)
					FLD_LAT: coord_char(c, LAT_DEG_DIGITS);
					FLD_LON: coord_char(c, LON_DEG_DIGITS);
					FLD_LAT_HEMI, FLD_LON_HEMI: begin
						// only the first character of a hemisphere field counts
						if (ndig == 0) begin
							ndig = 1;
							if (fld == FLD_LAT_HEMI && c == CH_SOUTH)
								lat_acc = -lat_acc;
							if (fld == FLD_LON_HEMI && c == CH_WEST)
								lon_acc = -lon_acc;
						end
					end
					FLD_TIME: begin
						if (c >= CH_ZERO && c <= CH_NINE) begin
							if (!point_seen)
								time_acc = (time_acc * 10 + (c - CH_ZERO)) % TIME_MOD;
						end else if (c == CH_POINT) begin
							point_seen = 1'b1;
						end
					end
					FLD_STATUS: begin
						if (!stat_taken) begin
							stat_ch    = c;
							stat_taken = 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	endfunction

	// Sentence assembly helpers
	function automatic void put_char(logic [7:0] c);
		line_q.push_back(c);
	endfunction

	function automatic void put_str(string s);
		foreach (s[i])
			put_char(s[i]);
	endfunction

	function automatic void put_digits(int unsigned n);
		repeat (n)
			put_char(CH_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	function automatic void put_num(int unsigned v, int unsigned w);
		int unsigned p;
		p = 1;
		repeat (w - 1)
			p *= 10;
		repeat (w) begin
			put_char(CH_ZERO + 8'((v / p) % 10));
			p /= 10;
		end
	endfunction

	// Any byte that does not change the sentence structure
	function automatic logic [7:0] junk_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_DOLLAR || c == CH_COMMA || c == CH_STAR);
		return c;
	endfunction

	function automatic void random_coord(int unsigned deg_digits, int unsigned deg_top);
		int unsigned shape;
		shape = $urandom_range(0, 15);
		if (shape == 0)
			return;
		if (shape == 1) begin
			repeat (deg_digits + 2)
				put_char(CH_NINE);
			put_char(CH_POINT);
			repeat (7)
				put_char(CH_NINE);
			return;
		end
		if (shape == 2)
			put_digits(deg_digits);
		else
			put_num($urandom_range(0, deg_top), deg_digits);
		if (shape == 3)
			put_digits($urandom_range(0, 4));
		else
			put_num($urandom_range(0, 59), 2);
		if (shape == 4)
			put_char(junk_char());
		if ($urandom_range(0, 5) != 0) begin
			put_char(CH_POINT);
			put_digits($urandom_range(0, 8));
			if (shape == 5) begin
				put_char(CH_POINT);
				put_digits(2);
			end
		end
	endfunction

	function automatic void random_hemi(logic [7:0] pos_ch, logic [7:0] neg_ch);
		case ($urandom_range(0, 9))
			0: ;
			1: put_char(junk_char());
			2: begin
				put_char(neg_ch);
				put_char(pos_ch);
			end
			default: put_char($urandom_range(0, 1) ? neg_ch : pos_ch);
		endcase
	endfunction

	// A mostly well formed sentence; some are cut short or closed early
	function automatic void random_sentence();
		string       hexd;
		int unsigned cut;
		hexd = "0123456789ABCDEF";
		line_q.delete();
		put_char(CH_DOLLAR);
		put_str("GPGLL");
		put_char(CH_COMMA);
		random_coord(2, 90);
		put_char(CH_COMMA);
		random_hemi(CH_NORTH, CH_SOUTH);
		put_char(CH_COMMA);
		random_coord(3, 180);
		put_char(CH_COMMA);
		random_hemi(CH_EAST, CH_WEST);
		put_char(CH_COMMA);
		case ($urandom_range(0, 9))
			0: ;
			1: put_digits($urandom_range(1, 9));
			2: put_str("999999.99");
			default: begin
				put_num($urandom_range(0, 23), 2);
				put_num($urandom_range(0, 59), 2);
				put_num($urandom_range(0, 59), 2);
				if ($urandom_range(0, 1)) begin
					put_char(CH_POINT);
					put_digits(2);
				end
			end
		endcase
		put_char(CH_COMMA);
		case ($urandom_range(0, 7))
			0: ;
			1: put_char(junk_char());
			2: put_char(CH_VOID);
			default: put_char(CH_OK);
		endcase
		// fields past the status
		if ($urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, 4)) begin
				put_char(CH_COMMA);
				put_char(junk_char());
			end
		end
		put_char(CH_STAR);
		put_char(hexd[$urandom_range(0, 15)]);
		put_char(hexd[$urandom_range(0, 15)]);
		put_char(CH_CR);
		put_char(CH_LF);
		// broken sentences: truncated, or closed early
		case ($urandom_range(0, 11))
			0, 1: begin
				cut = $urandom_range(1, line_q.size() - 1);
				while (line_q.size() > cut)
					void'(line_q.pop_back());
				if ($urandom_range(0, 1))
					put_char(CH_STAR);
			end
			default: ;
		endcase
	endfunction

	// Drive one character and wait for it to be taken
	task automatic send_char(input logic [7:0] c);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(1, 12))
				@(negedge clk);
		end
		char_valid <= 1'b1;
		char_in    <= c;
		do
			@(posedge clk);
		while (char_stall);
		parse_char(c);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_str(input string s);
		foreach (s[i])
			send_char(s[i]);
	endtask

	task automatic send_line();
		foreach (line_q[i])
			send_char(line_q[i]);
	endtask

	// Hold off the sender until every pending fix has come out
	task automatic wait_drained();
		char_valid <= 1'b0;
		while (fix_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_empty_fields();
		send_str("ab*,");
		send_char(8'h80);
		send_str("$*");
		send_str("$GPGLL,,,,,,*");
	endtask

	task automatic test_limits();
		send_str("$,9000.0,S,18000.0,W,235959,A*");
		send_str("$,9959.99999,N,99959.999999,E,999999.99,V*");
		send_str("$,0000.00000,N,00000.00000,E,000000,A*");
	endtask

	task automatic test_odd_fields();
		send_str("$,12$,4807.038,S,01131,W,1234567.89,A,B,C,D*");
		send_str("$,4x8..07.5,SN,0113199.5,WW,12:35.1,");
		send_char(8'hFF);
		send_str("*7F$,48,N,011,E,1,A*");
	endtask

	task automatic test_random();
		int unsigned first_char;
		bit          drained;
		first_char = chars_sent;
		drained    = 1'b0;
		while (chars_sent - first_char < RANDOM_CHARS) begin
			// calm stretches, and no idling at all near the end
			if (chars_sent - first_char > RANDOM_CHARS * 4 / 5)
				idle_on = 1'b0;
			else
				idle_on = ($urandom_range(0, 4) != 0);
			if (!drained && chars_sent - first_char > RANDOM_CHARS / 2) begin
				drained = 1'b1;
				wait_drained();
			end
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 6))
					send_char(8'($urandom_range(0, 255)));
			end
			random_sentence();
			send_line();
		end
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%s mismatch: expected %0d, got %0d", name, want, got);
		end
	endtask

	// Output side: random stall bursts
	always @(negedge clk) begin
		if (stall_left != 0) begin
			pos_stall <= 1'b1;
			stall_left--;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			pos_stall  <= 1'b1;
			stall_left = $urandom_range(0, 11);
		end else begin
			pos_stall <= 1'b0;
		end
	end

	// Fix checker and run limit
	always @(posedge clk) begin
		fix_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else if (arst_n && pos_valid && !pos_stall) begin
			if (fix_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected fix: lat %0d lon %0d", latitude, longitude);
			end else begin
				want = fix_q.pop_front();
				check_field("latitude", $signed(want.lat), latitude);
				check_field("longitude", $signed(want.lon), longitude);
				check_field("hours", want.hh, hours);
				check_field("minutes", want.mm, minutes);
				check_field("seconds", want.ss, seconds);
				check_field("status", want.st, status);
			end
		end
	end

	initial begin
		char_valid = 1'b0;
		char_in    = '0;
		pos_stall  = 1'b0;
		arst_n     = 1'b0;
		open_sentence();
		in_sent = 1'b0;
		repeat (6)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_fields();
		test_limits();
		test_odd_fields();
		wait_drained();
		test_random();

		wait_drained();
		repeat (LATENCY * 4)
			@(negedge clk);
		if (errors == 0 && fix_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* filelist.f */
sv/gll_pkg.sv
sv/gll_front.sv
sv/gll_scale.sv
sv/nmea_gll_position_parser.sv
bench/tb_top.sv
